// ===== rtl/pfr_pkg.sv =====
// shared types and constants for the page frame replacement block
package pfr_pkg;

  localparam int unsigned StampW = 32;

  typedef enum logic [1:0] {
    POL_FIFO  = 2'd0,
    POL_CLOCK = 2'd1,
    POL_LRU   = 2'd2,
    POL_RSVD  = 2'd3
  } policy_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture input item and read its flags
    logic access;     // apply access item
    logic hit_only;   // fault for a resident page
    logic scan_free;  // step free frame search
    logic scan_clock; // step clock sweep
    logic scan_lru;   // step lru search
    logic scan_init;  // reset scan pointer
    logic alloc;      // commit allocation at chosen frame
    logic fifo_pick;  // choose fifo frame
    logic clock_pick; // choose frame under the clock hand
  } pfr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mode;
    logic present;
    logic free_found;
    logic scan_done;
    logic clock_found;
  } pfr_sts_t;

endpackage

// ===== rtl/pfr_ctrl.sv =====
// controller state machine for the page frame replacement block
module pfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [1:0]        policy_i,
  input  pfr_pkg::pfr_sts_t sts_i,
  output pfr_pkg::pfr_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DEC   = 8'b0000_0010,
    S_FREE  = 8'b0000_0100,
    S_CLOCK = 8'b0000_1000,
    S_LRU   = 8'b0001_0000,
    S_ALLOC = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_PICK  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts_i.mode) begin
          cmd_o.access = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.present) begin
          cmd_o.hit_only = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = S_FREE;
        end
      end
      S_FREE: begin
        if (sts_i.free_found) begin
          // this step latches the free frame
          cmd_o.scan_free = 1'b1;
          state_d = S_ALLOC;
        end else if (sts_i.scan_done) begin
          state_d = S_PICK;
        end else begin
          cmd_o.scan_free = 1'b1;
        end
      end
      S_PICK: begin
        cmd_o.scan_init = 1'b1;
        if (policy_i == pfr_pkg::POL_CLOCK) begin
          state_d = S_CLOCK;
        end else if (policy_i == pfr_pkg::POL_LRU) begin
          state_d = S_LRU;
        end else begin
          cmd_o.scan_init = 1'b0;
          cmd_o.fifo_pick = 1'b1;
          state_d = S_ALLOC;
        end
      end
      S_CLOCK: begin
        if (sts_i.clock_found) begin
          cmd_o.clock_pick = 1'b1;
          state_d = S_ALLOC;
        end else begin
          cmd_o.scan_clock = 1'b1;
        end
      end
      S_LRU: begin
        if (sts_i.scan_done) begin
          state_d = S_ALLOC;
        end else begin
          cmd_o.scan_lru = 1'b1;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/pfr_dp.sv =====
// datapath for the page frame replacement block: page table, frame map, scans
module pfr_dp #(
  parameter int unsigned PAGES  = 32,
  parameter int unsigned FRAMES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        mode_i,
  input  logic [$clog2(PAGES)-1:0]    page_i,
  input  logic                        write_i,
  input  logic [1:0]                  policy_i,
  input  pfr_pkg::pfr_cmd_t           cmd_i,
  output pfr_pkg::pfr_sts_t           sts_o,
  output logic                        hit_o,
  output logic [$clog2(FRAMES)-1:0]   frame_o,
  output logic                        evicted_valid_o,
  output logic [$clog2(PAGES)-1:0]    evicted_page_o,
  output logic                        writeback_o
);

  localparam int unsigned PW = $clog2(PAGES);
  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(2 * FRAMES + 2);
  localparam logic [FW-1:0] LastFrame = FW'(FRAMES - 1);

  logic [PAGES-1:0]  present_q, used_q, dirty_q;
  logic [FW-1:0]     pframe_q [PAGES];
  logic [pfr_pkg::StampW-1:0] stamp_q [PAGES];
  logic [FRAMES-1:0] own_v_q;
  logic [PW-1:0]     own_p_q [FRAMES];
  logic [pfr_pkg::StampW-1:0] counter_q;
  logic [FW-1:0]     last_q;

  logic              mode_q, write_q;
  logic [PW-1:0]     page_q;
  logic [FW-1:0]     ptr_q, best_q;
  logic [CW-1:0]     cnt_q;
  logic [pfr_pkg::StampW-1:0] best_s_q;
  logic              hit_q, ev_v_q, wb_q;
  logic [FW-1:0]     frame_q;
  logic [PW-1:0]     ev_p_q;

  logic [FW-1:0]     ptr_nxt, last_nxt, vic;
  logic [PW-1:0]     ptr_page, vic_page, in_page;
  logic [pfr_pkg::StampW-1:0] cnt_nxt;

  function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] f);
    wrap_inc = (f == LastFrame) ? '0 : f + 1'b1;
  endfunction

  // page number folded into range, one subtract is enough
  assign in_page  = ({1'b0, page_i} >= (PW + 1)'(PAGES)) ?
                    PW'({1'b0, page_i} - (PW + 1)'(PAGES)) : page_i;
  assign ptr_nxt  = wrap_inc(ptr_q);
  assign last_nxt = wrap_inc(last_q);
  assign ptr_page = own_p_q[ptr_q];
  assign vic      = best_q;
  assign vic_page = own_p_q[vic];
  assign cnt_nxt  = (counter_q == '1) ? counter_q : counter_q + 1'b1;

  assign sts_o.mode        = mode_q;
  assign sts_o.present     = present_q[page_q];
  assign sts_o.free_found  = !own_v_q[ptr_q] && (cnt_q < CW'(FRAMES));
  assign sts_o.scan_done   = (cnt_q == CW'(FRAMES));
  assign sts_o.clock_found = !used_q[ptr_page] || (cnt_q == CW'(2 * FRAMES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      used_q    <= '0;
      dirty_q   <= '0;
      own_v_q   <= '0;
      counter_q <= '0;
      last_q    <= LastFrame;
      for (int i = 0; i < PAGES; i++) stamp_q[i] <= '0;
    end else begin
      if (cmd_i.access) begin
        counter_q <= cnt_nxt;
        if (present_q[page_q]) begin
          used_q[page_q]  <= 1'b1;
          if (write_q) dirty_q[page_q] <= 1'b1;
          stamp_q[page_q] <= cnt_nxt;
        end
      end
      if (cmd_i.scan_clock && used_q[ptr_page]) begin
        used_q[ptr_page] <= 1'b0;
      end
      if (cmd_i.alloc) begin
        last_q <= vic;
        if (own_v_q[vic]) begin
          present_q[vic_page] <= 1'b0;
          used_q[vic_page]    <= 1'b0;
          dirty_q[vic_page]   <= 1'b0;
        end
        present_q[page_q] <= 1'b1;
        used_q[page_q]    <= 1'b0;
        dirty_q[page_q]   <= 1'b0;
        own_v_q[vic]      <= 1'b1;
      end
    end
  end

  // payload state without reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      own_p_q[vic]     <= page_q;
      pframe_q[page_q] <= vic;
    end
  end

  // item, scan and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_free || cmd_i.scan_clock || cmd_i.scan_lru) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      page_q  <= in_page;
      write_q <= write_i;
    end
    if (cmd_i.scan_init) begin
      // free scan starts at 0, clock at last+1, lru at last
      if (!(&own_v_q)) begin
        ptr_q <= '0;
      end else if (policy_i == pfr_pkg::POL_CLOCK) begin
        ptr_q <= last_nxt;
      end else begin
        ptr_q <= last_q;
      end
      best_q   <= last_q;
      best_s_q <= stamp_q[own_p_q[last_q]];
    end else if (cmd_i.scan_free) begin
      if (!own_v_q[ptr_q]) best_q <= ptr_q;
      ptr_q <= ptr_nxt;
    end else if (cmd_i.scan_clock) begin
      ptr_q <= ptr_nxt;
    end else if (cmd_i.scan_lru) begin
      if (stamp_q[ptr_page] < best_s_q) begin
        best_q   <= ptr_q;
        best_s_q <= stamp_q[ptr_page];
      end
      ptr_q <= ptr_nxt;
    end else if (cmd_i.fifo_pick) begin
      best_q <= last_nxt;
    end else if (cmd_i.clock_pick) begin
      best_q <= ptr_q;
    end
    if (cmd_i.access) begin
      hit_q  <= present_q[page_q];
      frame_q <= present_q[page_q] ? pframe_q[page_q] : '0;
      ev_v_q <= 1'b0;
      ev_p_q <= '0;
      wb_q   <= 1'b0;
    end else if (cmd_i.hit_only) begin
      hit_q  <= 1'b1;
      frame_q <= pframe_q[page_q];
      ev_v_q <= 1'b0;
      ev_p_q <= '0;
      wb_q   <= 1'b0;
    end else if (cmd_i.alloc) begin
      hit_q  <= 1'b1;
      frame_q <= vic;
      ev_v_q <= own_v_q[vic];
      ev_p_q <= own_v_q[vic] ? vic_page : '0;
      wb_q   <= own_v_q[vic] & dirty_q[vic_page];
    end
  end

  assign hit_o           = hit_q;
  assign frame_o         = frame_q;
  assign evicted_valid_o = ev_v_q;
  assign evicted_page_o  = ev_p_q;
  assign writeback_o     = wb_q;

endmodule

// ===== rtl/page_frame_replacement_top.sv =====
// top level of the page frame replacement block
// one item at a time: an access or resident fault goes from decode to the result transfer;
// a fault scans for a free frame, and with all frames full it picks a victim under fifo,
// clock or lru; the next input transfer follows the result transfer
// reset clears page flags, stamps, frame map valid bits, counter, policy, and sets last frame to FRAMES-1
module page_frame_replacement_top #(
  parameter int unsigned PAGES  = 32,
  parameter int unsigned FRAMES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      policy_we_i,
  input  logic [1:0]                policy_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [$clog2(PAGES)-1:0]  page_i,
  input  logic                      write_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [$clog2(FRAMES)-1:0] frame_o,
  output logic                      evicted_valid_o,
  output logic [$clog2(PAGES)-1:0]  evicted_page_o,
  output logic                      writeback_o
);

  logic [1:0]        policy_q;
  pfr_pkg::pfr_cmd_t cmd;
  pfr_pkg::pfr_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pfr_pkg::POL_FIFO;
    end else if (policy_we_i) begin
      policy_q <= policy_i;
    end
  end

  pfr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .policy_i (policy_q), .sts_i (sts), .cmd_o (cmd)
  );

  pfr_dp #(.PAGES(PAGES), .FRAMES(FRAMES)) u_dp (
    .clk_i, .rst_ni, .mode_i, .page_i, .write_i, .policy_i (policy_q),
    .cmd_i (cmd), .sts_o (sts), .hit_o, .frame_o, .evicted_valid_o,
    .evicted_page_o, .writeback_o
  );

  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_o))
    else $error("result changed while stalled");
  a_evict_implies_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> hit_o) else $error("eviction without hit");

endmodule

// ===== tb/page_frame_replacement_top_tb.sv =====
// self-checking testbench for the page frame replacement block
module page_frame_replacement_top_tb;

  localparam int unsigned NPAGES  = 32;
  localparam int unsigned NFRAMES = 8;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic       mode;
    logic [4:0] page;
    logic       write;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] frame;
    logic       ev_valid;
    logic [4:0] ev_page;
    logic       wb;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic policy_we_i = 1'b0;
  logic [1:0] policy_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic [4:0] page_i = '0;
  logic write_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [2:0] frame_o;
  logic evicted_valid_o;
  logic [4:0] evicted_page_o;
  logic writeback_o;

  page_frame_replacement_top #(.PAGES(NPAGES), .FRAMES(NFRAMES)) u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // page table mirror
  logic [1:0]  mdl_policy;
  logic        own_valid [NFRAMES];
  logic [4:0]  own_page [NFRAMES];
  logic [2:0]  pg_frame [NPAGES];
  logic        pg_present [NPAGES];
  logic        pg_used [NPAGES];
  logic        pg_dirty [NPAGES];
  logic [31:0] pg_stamp [NPAGES];
  logic [31:0] acc_count;
  logic [2:0]  last_alloc;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   mismatches = 0;
  int   n_rsps = 0;
  int   n_evict = 0;
  int   n_wb = 0;
  int   idle_cycles = 0;
  bit   no_idle = 1'b0;

  task automatic reset_mirror();
    mdl_policy = pfr_pkg::POL_FIFO;
    for (int i = 0; i < NFRAMES; i++) begin
      own_valid[i] = 1'b0;
      own_page[i] = '0;
    end
    for (int i = 0; i < NPAGES; i++) begin
      pg_frame[i] = '0;
      pg_present[i] = 1'b0;
      pg_used[i] = 1'b0;
      pg_dirty[i] = 1'b0;
      pg_stamp[i] = '0;
    end
    acc_count = '0;
    last_alloc = 3'(NFRAMES - 1);
  endtask

  function automatic rsp_t translate(req_t r);
    rsp_t o;
    logic [2:0] f;
    logic [2:0] best;
    logic [31:0] best_s;
    logic found;
    logic [4:0] old;
    o = '0;
    if (!r.mode) begin
      if (acc_count != 32'hffff_ffff) acc_count++;
      if (pg_present[r.page]) begin
        pg_used[r.page] = 1'b1;
        if (r.write) pg_dirty[r.page] = 1'b1;
        pg_stamp[r.page] = acc_count;
        o.hit = 1'b1;
        o.frame = pg_frame[r.page];
      end
    end else if (pg_present[r.page]) begin
      o.hit = 1'b1;
      o.frame = pg_frame[r.page];
    end else begin
      found = 1'b0;
      f = '0;
      for (int i = 0; i < NFRAMES; i++) begin
        if (!found && !own_valid[i]) begin
          f = 3'(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (mdl_policy == pfr_pkg::POL_CLOCK) begin
          f = last_alloc + 3'd1;
          for (int n = 0; n < 2 * NFRAMES; n++) begin
            if (!found) begin
              if (!pg_used[own_page[f]]) found = 1'b1;
              else begin
                pg_used[own_page[f]] = 1'b0;
                f = f + 3'd1;
              end
            end
          end
        end else if (mdl_policy == pfr_pkg::POL_LRU) begin
          best = last_alloc;
          best_s = pg_stamp[own_page[best]];
          for (int i = 1; i < NFRAMES; i++) begin
            if (pg_stamp[own_page[3'(last_alloc + i)]] < best_s) begin
              best = 3'(last_alloc + i);
              best_s = pg_stamp[own_page[best]];
            end
          end
          f = best;
        end else begin
          f = last_alloc + 3'd1;
        end
      end
      last_alloc = f;
      if (own_valid[f]) begin
        old = own_page[f];
        o.ev_valid = 1'b1;
        o.ev_page = old;
        o.wb = pg_dirty[old];
        pg_present[old] = 1'b0;
        pg_used[old] = 1'b0;
        pg_dirty[old] = 1'b0;
      end
      pg_frame[r.page] = f;
      pg_present[r.page] = 1'b1;
      pg_used[r.page] = 1'b0;
      pg_dirty[r.page] = 1'b0;
      own_valid[f] = 1'b1;
      own_page[f] = r.page;
      o.hit = 1'b1;
      o.frame = f;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want, n_rsps);
    mismatches++;
  endtask

  function automatic bit want_idle();
    return !no_idle && ($urandom_range(99) < 18);
  endfunction

  // driver: the valid stays high across back-to-back transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() > 0 && !want_idle()) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= r.mode;
          page_i <= r.page;
          write_i <= r.write;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= want_idle();
    end
  end

  // predict at input transfer, check at output transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(translate('{mode: mode_i, page: page_i, write: write_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (hit_o !== e.hit) report_mismatch("hit", hit_o, e.hit);
          if (frame_o !== e.frame) report_mismatch("frame", frame_o, e.frame);
          if (evicted_valid_o !== e.ev_valid)
            report_mismatch("evicted_valid", evicted_valid_o, e.ev_valid);
          if (e.ev_valid && evicted_page_o !== e.ev_page)
            report_mismatch("evicted_page", evicted_page_o, e.ev_page);
          if (writeback_o !== e.wb) report_mismatch("writeback", writeback_o, e.wb);
          n_evict += e.ev_valid;
          n_wb += e.wb;
        end
        n_rsps++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_rsps.size());
      $display("page_frame_replacement_top_tb failed");
      $finish;
    end
  end

  task automatic push_req(logic m, logic [4:0] p, logic w);
    pending_reqs.push_back('{mode: m, page: p, write: w});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_policy(logic [1:0] p);
    @(posedge clk_i);
    policy_we_i <= 1'b1;
    policy_i <= p;
    @(posedge clk_i);
    policy_we_i <= 1'b0;
    mdl_policy = p;
  endtask

  initial begin
    logic [1:0] pols [5];
    pols = '{pfr_pkg::POL_FIFO, pfr_pkg::POL_CLOCK, pfr_pkg::POL_LRU,
             pfr_pkg::POL_RSVD, pfr_pkg::POL_LRU};
    reset_mirror();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: absent access, fill all frames, hits, writes, evictions
    push_req(1'b0, 5'd0, 1'b1);
    push_req(1'b1, 5'd31, 1'b1);
    push_req(1'b1, 5'd31, 1'b0);
    for (int i = 0; i < NFRAMES; i++) push_req(1'b1, 5'(i), 1'b0);
    push_req(1'b0, 5'd31, 1'b1);
    push_req(1'b0, 5'd2, 1'b0);
    push_req(1'b0, 5'd3, 1'b1);
    push_req(1'b0, 5'd20, 1'b0);
    push_req(1'b1, 5'd20, 1'b0);
    push_req(1'b1, 5'd21, 1'b0);
    push_req(1'b1, 5'd22, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      set_policy(pols[ph]);
      no_idle = (ph == 2);
      for (int k = 0; k < 200; k++) begin
        // mostly a small working set so hits and evictions both happen
        logic [4:0] p;
        p = ($urandom_range(99) < 75) ? 5'($urandom_range(11)) : 5'($urandom);
        push_req($urandom_range(99) < 40, p, 1'($urandom_range(1)));
      end
      wait_drained();
    end
    $display("checked %0d results over all victim policies", n_rsps);
    $display("saw %0d evictions, %0d with writeback", n_evict, n_wb);
    if (mismatches == 0) begin
      $display("page_frame_replacement_top_tb passed");
    end else begin
      $display("page_frame_replacement_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pfr_pkg.sv
rtl/pfr_ctrl.sv
rtl/pfr_dp.sv
rtl/page_frame_replacement_top.sv
tb/page_frame_replacement_top_tb.sv
